// ===== rtl/core/vn_pkg.sv =====
// Package for the vector normalization block: widths, constants and shared types.
// No dependencies; the other files, apart from vn_if, refer to it by scoped names.
package vn_pkg;

  localparam int COMPONENT_BITS = 32;
  localparam int MAG_BITS       = COMPONENT_BITS;
  localparam int SUM_BITS       = 2 * MAG_BITS + 2;
  localparam int LEN_BITS       = MAG_BITS + 1;
  localparam int OUT_BITS       = 32;
  localparam int QUOT_BITS      = 31;
  localparam int THRESH_BITS    = 16;
  localparam int NUM_BITS       = MAG_BITS + 30;
  localparam int LANES          = 3;
  localparam logic [OUT_BITS-1:0] ONE_Q30 = OUT_BITS'(32'h4000_0000);

  typedef logic [MAG_BITS-1:0]  mag_t;
  typedef logic [SUM_BITS-1:0]  sum_t;
  typedef logic [LEN_BITS-1:0]  len_t;
  typedef logic [QUOT_BITS-1:0] quot_t;
  typedef logic [NUM_BITS-1:0]  num_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       fallback;
  } side_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

// ===== rtl/core/vn_if.sv =====
// Valid/ready channel interface carrying a payload of a given type.
// Generic over the payload type; it does not refer to vn_pkg itself.
interface vn_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vn_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on vn_pkg for widths; side data rides along with each transaction.
module vn_isqrt (
  input  logic                                 clk,
  input  logic                                 en,
  input  vn_pkg::sum_t                         sum_in,
  input  logic [vn_pkg::LANES*vn_pkg::MAG_BITS-1:0] side_in,
  input  logic [vn_pkg::LANES-1:0]             sign_in,
  output vn_pkg::len_t                         len_out,
  output logic [vn_pkg::LANES*vn_pkg::MAG_BITS-1:0] side_out,
  output logic [vn_pkg::LANES-1:0]             sign_out
);
  localparam int N = vn_pkg::LEN_BITS;
  localparam int SW = vn_pkg::SUM_BITS + 2;

  logic [SW-1:0]        rem_r  [0:N];
  logic [N-1:0]         root_r [0:N];
  logic [SW-1:0]        rad_r  [0:N];
  logic [vn_pkg::LANES*vn_pkg::MAG_BITS-1:0] side_r [0:N];
  logic [vn_pkg::LANES-1:0] sign_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= {2'b00, sum_in};
      side_r[0] <= side_in;
      sign_r[0] <= sign_in;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [SW-1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_r[s][SW-3:0], rad_r[s][2*N-1 -: 2]};
      trial  = SW'({root_r[s], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[s+1]  <= rem_sh - trial;
          root_r[s+1] <= {root_r[s][N-2:0], 1'b1};
        end else begin
          rem_r[s+1]  <= rem_sh;
          root_r[s+1] <= {root_r[s][N-2:0], 1'b0};
        end
        rad_r[s+1]  <= rad_r[s] << 2;
        side_r[s+1] <= side_r[s];
        sign_r[s+1] <= sign_r[s];
      end
    end
  end

  assign len_out  = root_r[N];
  assign side_out = side_r[N];
  assign sign_out = sign_r[N];
endmodule

// ===== rtl/core/vn_div_lane.sv =====
// One divider lane: pipelined restoring division of magnitude * 2^30 by the length.
// Depends on vn_pkg; three copies run in parallel, one per component.
module vn_div_lane (
  input  logic          clk,
  input  logic          en,
  input  vn_pkg::mag_t  mag_in,
  input  vn_pkg::len_t  len_in,
  output vn_pkg::quot_t quot_out
);
  localparam int Q = vn_pkg::QUOT_BITS;
  localparam int L = vn_pkg::LEN_BITS;
  localparam int NB = vn_pkg::NUM_BITS;

  // The quotient is at most 2^30, so the high part of the numerator is below len.
  logic [L:0]      rem_r [0:Q];
  logic [Q-1:0]    num_r [0:Q];
  logic [L-1:0]    den_r [0:Q];
  logic [Q-1:0]    q_r   [0:Q];

  logic [NB-1:0] num_full;
  assign num_full = {mag_in, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (L+1)'(num_full[NB-1 -: (NB-Q)]);
      num_r[0] <= num_full[Q-1:0];
      den_r[0] <= len_in;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_stage
    logic [L+1:0] sh;
    always_comb sh = {rem_r[s], num_r[s][Q-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= {2'b00, den_r[s]}) begin
          rem_r[s+1] <= (L+1)'(sh - {2'b00, den_r[s]});
          q_r[s+1]   <= {q_r[s][Q-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= sh[L:0];
          q_r[s+1]   <= {q_r[s][Q-2:0], 1'b0};
        end
        num_r[s+1] <= num_r[s] << 1;
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign quot_out = q_r[Q];
endmodule

// ===== rtl/core/vn_merge.sv =====
// Merging stage: applies signs to the lane quotients or selects the axis fallback.
// Depends on vn_pkg for widths, axis codes and the side-band struct.
module vn_merge (
  input  logic                               clk,
  input  logic                               en,
  input  vn_pkg::quot_t                      quot [vn_pkg::LANES],
  input  logic [vn_pkg::LANES-1:0]           neg,
  input  vn_pkg::side_t                      side,
  output logic [vn_pkg::OUT_BITS-1:0]        unit_r [vn_pkg::LANES],
  output logic                               fallback_r
);
  always_ff @(posedge clk) begin
    if (en) begin
      fallback_r <= side.fallback;
      for (int i = 0; i < vn_pkg::LANES; i++) begin
        if (side.fallback) begin
          unit_r[i] <= (side.axis == 2'(i)) ? vn_pkg::ONE_Q30 : '0;
        end else begin
          unit_r[i] <= neg[i] ? -vn_pkg::OUT_BITS'(quot[i])
                              : vn_pkg::OUT_BITS'(quot[i]);
        end
      end
    end
  end
endmodule

// ===== rtl/core/vector3_normalize.sv =====
// Normalizes a signed Q16.16 3D vector to a signed Q2.30 unit vector, rounding
// toward zero, with an axis fallback when the length is at or below the
// threshold written through cfg_wdata. One transaction is accepted per cycle
// while the output side keeps taking results. Each passes in order through the
// magnitudes and the sum of squares, the square root (input register and 33
// stages), the fallback decision, the three parallel divider lanes (input
// register and 31 stages), merging and the two-entry output buffer. The whole
// pipeline holds while the buffer is full, so after an output stall the input
// is ready again in the cycle after a result is taken.
// Depends on vn_pkg, vn_if, vn_isqrt, vn_div_lane and vn_merge.
module vector3_normalize (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic [vn_pkg::THRESH_BITS-1:0] cfg_wdata,
  vn_if.sink     in_ch,
  vn_if.source   out_ch
);
  localparam int LAT = 2 + (vn_pkg::LEN_BITS + 1) + 1 + (vn_pkg::QUOT_BITS + 1) + 1;
  localparam int MB = vn_pkg::MAG_BITS;

  logic [vn_pkg::THRESH_BITS-1:0] thresh_r;
  logic [LAT-1:0]                 vld_r;
  logic                           en;

  logic [3*vn_pkg::OUT_BITS:0] slot_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;

  // Pipeline advances while the output buffer has a free entry.
  assign en = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= '0;
    else if (cfg_we) thresh_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // Stage 1: magnitudes.
  vn_pkg::mag_t mag_r [3];
  logic [2:0]   neg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [MB-1:0] c;
        c = in_ch.data[i*MB +: MB];
        neg_r[i] <= c[MB-1];
        mag_r[i] <= c[MB-1] ? -c : c;
      end
    end
  end

  // Stage 2: sum of squares.
  logic [2*MB-1:0] sq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = mag_r[i] * mag_r[i];
    end
  end

  vn_pkg::sum_t sum_r;
  logic [3*MB-1:0] mag2_r;
  logic [2:0]      neg2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= vn_pkg::SUM_BITS'(sq[0]) + vn_pkg::SUM_BITS'(sq[1])
              + vn_pkg::SUM_BITS'(sq[2]);
      mag2_r <= {mag_r[2], mag_r[1], mag_r[0]};
      neg2_r <= neg_r;
    end
  end

  vn_pkg::len_t len_s;
  logic [3*MB-1:0] mag_s;
  logic [2:0]      sg_s;
  vn_isqrt u_isqrt (
    .clk(clk), .en(en), .sum_in(sum_r), .side_in(mag2_r), .sign_in(neg2_r),
    .len_out(len_s), .side_out(mag_s), .sign_out(sg_s)
  );

  // Fallback decision.
  vn_pkg::len_t  len_d_r;
  logic [3*MB-1:0] mag_d_r;
  logic [2:0]    neg_d_r;
  vn_pkg::side_t side_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [MB-1:0] mx, my, mz;
      mx = mag_s[0 +: MB];
      my = mag_s[MB +: MB];
      mz = mag_s[2*MB +: MB];
      len_d_r  <= len_s;
      mag_d_r  <= mag_s;
      neg_d_r  <= sg_s;
      side_d_r.fallback <= (len_s <= vn_pkg::LEN_BITS'(thresh_r));
      if (mx > my && mx > mz)      side_d_r.axis <= vn_pkg::AXIS_X;
      else if (my > mz && my > mx) side_d_r.axis <= vn_pkg::AXIS_Y;
      else                         side_d_r.axis <= vn_pkg::AXIS_Z;
    end
  end

  // Side data delayed to match the divider lanes.
  vn_pkg::side_t side_p_r [vn_pkg::QUOT_BITS+1];
  logic [2:0]    neg_p_r  [vn_pkg::QUOT_BITS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      side_p_r[0] <= side_d_r;
      neg_p_r[0]  <= neg_d_r;
      for (int i = 1; i < vn_pkg::QUOT_BITS + 1; i++) begin
        side_p_r[i] <= side_p_r[i-1];
        neg_p_r[i]  <= neg_p_r[i-1];
      end
    end
  end

  vn_pkg::quot_t quot [3];
  vn_pkg::len_t  den;
  assign den = side_d_r.fallback ? vn_pkg::len_t'(1) : len_d_r;
  for (genvar g = 0; g < 3; g++) begin : g_lane
    vn_div_lane u_lane (
      .clk(clk), .en(en), .mag_in(side_d_r.fallback ? '0 : mag_d_r[g*MB +: MB]),
      .len_in(den), .quot_out(quot[g])
    );
  end

  logic [vn_pkg::OUT_BITS-1:0] unit_r [3];
  logic fb_r;
  vn_merge u_merge (
    .clk(clk), .en(en), .quot(quot), .neg(neg_p_r[vn_pkg::QUOT_BITS]),
    .side(side_p_r[vn_pkg::QUOT_BITS]), .unit_r(unit_r), .fallback_r(fb_r)
  );

  // Two-entry output buffer.
  logic push, pop;
  assign push = en && vld_r[LAT-1];
  assign pop  = out_ch.valid && out_ch.ready;
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= {fb_r, unit_r[2], unit_r[1], unit_r[0]};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = slot_r[rd_ptr_r];
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for vector3_normalize: random and directed vectors,
// random idling on both channels, expected unit vectors from a built-in predictor.
// Depends on vn_pkg, vn_if and the vector3_normalize RTL.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_x;
  } vec_in_t;

  typedef struct packed {
    logic               used_fallback;
    logic signed [31:0] unit_z;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_x;
  } vec_out_t;

  class unit_vector_board;
    vec_out_t   expected_q[$];
    logic [15:0] threshold;
    int         errors;
    int         checked;
    int         fallbacks;

    function new();
      threshold = 0;
      errors = 0;
      checked = 0;
      fallbacks = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void note_input(vec_in_t v);
      logic [31:0] mag [3];
      logic [65:0] sum_sq;
      logic [32:0] len, trial;
      logic [63:0] quot;
      logic [31:0] comp [3];
      vec_out_t r;
      comp[0] = v.comp_x;
      comp[1] = v.comp_y;
      comp[2] = v.comp_z;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
        sum_sq += 66'(mag[i]) * 66'(mag[i]);
      end
      len = 0;
      for (int b = 32; b >= 0; b--) begin
        trial = len | (33'd1 << b);
        if (66'(trial) * 66'(trial) <= sum_sq) len = trial;
      end
      r = '0;
      if (len <= 33'(threshold)) begin
        r.used_fallback = 1'b1;
        if (mag[0] > mag[1] && mag[0] > mag[2]) r.unit_x = vn_pkg::ONE_Q30;
        else if (mag[1] > mag[0] && mag[1] > mag[2]) r.unit_y = vn_pkg::ONE_Q30;
        else r.unit_z = vn_pkg::ONE_Q30;
      end else begin
        for (int i = 0; i < 3; i++) begin
          quot = (64'(mag[i]) << 30) / 64'(len);
          if (comp[i][31]) quot = -quot;
          if (i == 0) r.unit_x = quot[31:0];
          else if (i == 1) r.unit_y = quot[31:0];
          else r.unit_z = quot[31:0];
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(vec_out_t got);
      vec_out_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.used_fallback) fallbacks++;
      if (got.unit_x !== exp_r.unit_x)
        report($sformatf("unit_x got %h expected %h", got.unit_x, exp_r.unit_x));
      if (got.unit_y !== exp_r.unit_y)
        report($sformatf("unit_y got %h expected %h", got.unit_y, exp_r.unit_y));
      if (got.unit_z !== exp_r.unit_z)
        report($sformatf("unit_z got %h expected %h", got.unit_z, exp_r.unit_z));
      if (got.used_fallback !== exp_r.used_fallback)
        report($sformatf("used_fallback got %b expected %b",
                         got.used_fallback, exp_r.used_fallback));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vn_pkg::THRESH_BITS-1:0] cfg_wdata;

  vn_if #(.payload_t(vec_in_t))  in_ch  ();
  vn_if #(.payload_t(vec_out_t)) out_ch ();

  vector3_normalize DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  unit_vector_board board;
  bit no_idle;
  int hold_off_cycles;
  int sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic set_threshold(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.threshold = value;
  endtask

  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    vec_in_t v;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    v.comp_x = x;
    v.comp_y = y;
    v.comp_z = z;
    in_ch.valid <= 1'b1;
    in_ch.data  <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_input(v);
    sent++;
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] scaled_rand();
    logic [31:0] r;
    int shift;
    r = $urandom;
    shift = $urandom_range(0, 31);
    r = $signed(r) >>> shift;
    return r;
  endfunction

  task automatic random_phase(int count, int small_limit);
    logic [31:0] x, y, z, m;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 20) no_idle = 1'b1;
      if (n % 60 == 35) no_idle = 1'b0;
      case ($urandom_range(0, 5))
        0: send_vector($urandom, $urandom, $urandom);
        1, 2: send_vector(scaled_rand(), scaled_rand(), scaled_rand());
        3: begin
          x = $urandom_range(0, small_limit);
          y = $urandom_range(0, small_limit);
          z = $urandom_range(0, small_limit);
          if ($urandom_range(0, 1)) x = -x;
          if ($urandom_range(0, 1)) y = -y;
          if ($urandom_range(0, 1)) z = -z;
          send_vector(x, y, z);
        end
        4: begin
          m = $urandom_range(0, small_limit);
          send_vector($urandom_range(0, 1) ? m : -m, m, $urandom_range(0, 1) ? 32'd0 : -m);
        end
        default: begin
          m = scaled_rand();
          send_vector(m, $urandom_range(0, 1) ? 32'h8000_0000 : -m, m);
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin
    vec_out_t got;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      board.check_result(got);
    end
  end

  initial begin
    board = new();
    no_idle = 1'b0;
    hold_off_cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vector(32'h0, 32'h0, 32'h0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h0, 32'h0);
    send_vector(32'h0, 32'h7FFF_FFFF, 32'h0);
    send_vector(32'h0, 32'h0, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
    send_vector(32'h1, 32'h0, 32'h0);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    drain_and_settle();

    set_threshold(16'hFFFF);
    send_vector(32'h0, 32'h0, 32'h0);
    send_vector(32'h100, 32'h5, 32'h5);
    send_vector(-32'sd100, 32'h200, 32'h5);
    send_vector(32'h5, 32'h5, -32'sd300);
    send_vector(32'h100, -32'sd100, 32'h5);
    send_vector(32'h100, 32'h5, 32'h100);
    send_vector(32'h5, 32'h100, -32'sd100);
    send_vector(32'hFFFF, 32'h0, 32'h0);
    send_vector(32'h1_0000, 32'h0, 32'h0);
    send_vector(32'hFFFF_0001, 32'h0, 32'h0);
    send_vector(32'h8000_0000, 32'h0, 32'h0);
    drain_and_settle();

    random_phase(200, 70000);
    drain_and_settle();

    set_threshold(16'd0);
    hold_off_cycles = 400;
    random_phase(180, 3);
    drain_and_settle();

    set_threshold(16'($urandom));
    random_phase(180, 70000);
    drain_and_settle();

    set_threshold(16'd1000);
    random_phase(170, 1200);
    drain_and_settle();

    $display("Sent %0d vectors over five threshold settings; %0d results checked,",
             sent, board.checked);
    $display("%0d of them through the axis fallback.", board.fallbacks);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
